FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks an implication or expression on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/sid_pkg.sv
// Shared types, constants and the operation table of the SIC/XE decoder.
`timescale 1ns / 1ps
`default_nettype none
package sid_pkg;

	localparam int SYMBOL_SLOTS  = 64;
	localparam int LITERAL_SLOTS = 16;

	localparam int SYM_AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
	localparam int LIT_AW = (LITERAL_SLOTS > 1) ? $clog2(LITERAL_SLOTS) : 1;
	localparam int TBL_AW = (SYM_AW > LIT_AW) ? SYM_AW : LIT_AW;

	localparam int ADDR_W = 20;
	localparam int SLOT_W = 6;
	localparam int DIG_W  = 8;
	localparam int SYM_W  = ADDR_W;
	localparam int LIT_W  = ADDR_W + DIG_W;

	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 80;

	localparam logic [7:0] OP_RSUB  = 8'h4C;
	localparam logic [7:0] OP_CLEAR = 8'hB4;
	localparam logic [7:0] OP_LDB   = 8'h68;

	localparam logic [ADDR_W-1:0] DISP_HALF = 20'h007FF;
	localparam logic [ADDR_W-1:0] DISP_SPAN = 20'h01000;
	localparam logic [ADDR_W-1:0] PC_STEP   = 20'd3;

	localparam logic [2:0] FMT_DATA = 3'd0;
	localparam logic [2:0] FMT_2    = 3'd2;
	localparam logic [2:0] FMT_3    = 3'd3;
	localparam logic [2:0] FMT_4    = 3'd4;

	localparam logic [1:0] MODE_SIMPLE    = 2'd0;
	localparam logic [1:0] MODE_INDIRECT  = 2'd1;
	localparam logic [1:0] MODE_IMMEDIATE = 2'd2;

	localparam int OP_COUNT = 43;
	localparam logic [7:0] OPCODE_SET [OP_COUNT] = '{
		8'h18, 8'h58, 8'h40, 8'hB4, 8'h28, 8'h88, 8'h24, 8'h64, 8'h3C, 8'h30, 8'h34,
		8'h38, 8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08, 8'h6C, 8'h74, 8'h04, 8'hD0,
		8'h20, 8'h60, 8'h44, 8'hD8, 8'h4C, 8'hEC, 8'h0C, 8'h78, 8'h54, 8'h80, 8'hD4,
		8'h14, 8'h7C, 8'hE8, 8'h84, 8'h10, 8'h1C, 8'h5C, 8'hE0, 8'h2C, 8'hDC
	};

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_DECODE  = 2'd1,
		KIND_SYMBOL  = 2'd2,
		KIND_LITERAL = 2'd3
	} kind_e_t;

	typedef enum logic [2:0] {
		OK_SYMBOL   = 3'd0,
		OK_LITERAL  = 3'd1,
		OK_VALUE    = 3'd2,
		OK_REGISTER = 3'd3,
		OK_NONE     = 3'd4
	} okind_e_t;

	typedef struct packed {
		logic [4:0]        pad;
		logic [DIG_W-1:0]  literal_digits;
		logic              entry_valid;
		logic [SLOT_W-1:0] entry_index;
		logic [31:0]       instr_bytes;
		logic [ADDR_W-1:0] address;
	} in_data_t;

	typedef struct packed {
		logic [1:0]        pad;
		logic [SLOT_W-1:0] operand_index;
		okind_e_t          operand_kind;
		logic [ADDR_W-1:0] target_address;
		logic              indexed;
		logic [1:0]        addressing_mode;
		logic              opcode_known;
		logic [7:0]        opcode;
		logic [6:0]        length_bytes;
		logic [2:0]        format;
		logic [SLOT_W-1:0] label_index;
		logic              label_found;
		logic [ADDR_W-1:0] item_address;
	} out_data_t;

	typedef struct packed {
		logic              sym_we;
		logic              lit_we;
		logic [SLOT_W-1:0] index;
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [DIG_W-1:0]  digits;
	} tbl_wr_t;

	typedef struct packed {
		logic              start;
		logic              sel_lit;
		logic [ADDR_W-1:0] key;
	} srch_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] index;
		logic [DIG_W-1:0]  digits;
	} srch_rsp_t;

	typedef struct packed {
		logic [7:0]        opcode;
		logic              known;
		logic [2:0]        format;
		logic [6:0]        len;
		logic [1:0]        mode;
		logic              indexed;
		logic [ADDR_W-1:0] target;
		logic              is_ret;
		logic              is_reg;
		logic [3:0]        nibble;
	} dec_t;

endpackage
`default_nettype wire

FILE: rtl/sicxe_instruction_decoder_core.sv
// Record-start and table-load requests are completed as they are accepted; a decode request
// yields its result after the literal sweep at the counter on a literal hit and after further
// table sweeps otherwise. Throughput: one request at a time, set by the table sweep, which
// reads one slot per cycle through the RAM read port.
// Reset (arst_n low, asynchronous): location counter and base register clear, every table
// slot turns unused through its valid bit, and the output register empties.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sicxe_instruction_decoder_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// address[19:0], instr_bytes[51:20], entry_index[57:52], entry_valid[58],
	// literal_digits[66:59], zero fill[71:67]
	input  wire logic [sid_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// kind[1:0]
	input  wire logic [sid_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// item_address[19:0], label_found[20], label_index[26:21], format[29:27],
	// length_bytes[36:30], opcode[44:37], opcode_known[45], addressing_mode[47:46],
	// indexed[48], target_address[68:49], operand_kind[71:69], operand_index[77:72],
	// zero fill[79:78]
	output logic [sid_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import sid_pkg::*;

	// One-hot sequencer. A decode request walks through up to four table sweeps:
	// literal at the counter, symbol at the counter (label), symbol at the target,
	// literal at the target. The decode unit finishes long before the third sweep.
	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_LIT_HERE = 6'b000010,
		ST_SYM_HERE = 6'b000100,
		ST_SYM_TGT  = 6'b001000,
		ST_LIT_TGT  = 6'b010000,
		ST_OUT      = 6'b100000
	} state_t;

	state_t            state_q;
	in_data_t          in_d;
	kind_e_t           kind;
	logic              accept;
	logic              dec_go;
	tbl_wr_t           wr;
	srch_req_t         srch;
	srch_rsp_t         tbl_rsp;
	dec_t              dec;
	logic              dec_rdy;
	logic              searching;

	logic [ADDR_W-1:0] lc_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] here_q;
	logic              lit_here_q;
	logic [SLOT_W-1:0] lit_idx_q;
	logic [DIG_W-1:0]  lit_dig_q;
	logic              lab_found_q;
	logic [SLOT_W-1:0] lab_idx_q;
	okind_e_t          ok_q;
	logic [SLOT_W-1:0] oi_q;

	out_data_t         res;
	logic              out_free;
	logic              out_load;
	logic              m_valid_q;
	out_data_t         m_data_q;

	assign in_d          = in_data_t'(s_axis_tdata);
	assign kind          = kind_e_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign dec_go        = accept && (kind == KIND_DECODE);
	assign searching     = (state_q == ST_LIT_HERE) || (state_q == ST_SYM_HERE) ||
	                       (state_q == ST_SYM_TGT) || (state_q == ST_LIT_TGT);

	// Table loads write straight into the RAMs; no sweep can be running while idle.
	always_comb begin
		wr        = '0;
		wr.index  = in_d.entry_index;
		wr.valid  = in_d.entry_valid;
		wr.addr   = in_d.address;
		wr.digits = in_d.literal_digits;
		wr.sym_we = accept && (kind == KIND_SYMBOL);
		wr.lit_we = accept && (kind == KIND_LITERAL);
	end

	// After the first, each search starts in the cycle the previous sweep reports done.
	always_comb begin
		srch = '0;
		case (state_q)
			ST_IDLE: begin
				srch.start   = dec_go;
				srch.sel_lit = 1'b1;
				srch.key     = lc_q;
			end
			ST_LIT_HERE: begin
				srch.start   = tbl_rsp.done && !tbl_rsp.hit;
				srch.sel_lit = 1'b0;
				srch.key     = here_q;
			end
			ST_SYM_HERE: begin
				srch.start   = tbl_rsp.done && !dec.is_ret && !dec.is_reg;
				srch.sel_lit = 1'b0;
				srch.key     = dec.target;
			end
			ST_SYM_TGT: begin
				srch.start   = tbl_rsp.done && !tbl_rsp.hit;
				srch.sel_lit = 1'b1;
				srch.key     = dec.target;
			end
			default: begin
				srch = '0;
			end
		endcase
	end

	sid_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.req    (srch),
		.rsp    (tbl_rsp)
	);

	sid_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (dec_go),
		.instr_bytes (in_d.instr_bytes),
		.here        (lc_q),
		.base        (base_q),
		.dec         (dec),
		.rdy         (dec_rdy)
	);

	// Result assembly. A literal at the counter overrides the instruction decode.
	always_comb begin
		res              = '0;
		res.item_address = here_q;
		if (lit_here_q) begin
			res.format         = FMT_DATA;
			res.length_bytes   = lit_dig_q[DIG_W-1:1];
			res.target_address = here_q;
			res.operand_kind   = OK_LITERAL;
			res.operand_index  = lit_idx_q;
		end else begin
			res.label_found     = lab_found_q;
			res.label_index     = lab_idx_q;
			res.format          = dec.format;
			res.length_bytes    = dec.len;
			res.opcode          = dec.opcode;
			res.opcode_known    = dec.known;
			res.addressing_mode = dec.mode;
			res.indexed         = dec.indexed;
			res.target_address  = dec.target;
			res.operand_kind    = ok_q;
			res.operand_index   = oi_q;
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lc_q      <= '0;
			base_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_START)) begin
						lc_q <= in_d.address;
					end
					if (dec_go) begin
						state_q <= ST_LIT_HERE;
					end
				end
				ST_LIT_HERE: begin
					if (tbl_rsp.done) begin
						state_q <= tbl_rsp.hit ? ST_OUT : ST_SYM_HERE;
					end
				end
				ST_SYM_HERE: begin
					if (tbl_rsp.done) begin
						state_q <= (dec.is_ret || dec.is_reg) ? ST_OUT : ST_SYM_TGT;
					end
				end
				ST_SYM_TGT: begin
					if (tbl_rsp.done) begin
						state_q <= tbl_rsp.hit ? ST_OUT : ST_LIT_TGT;
					end
				end
				ST_LIT_TGT: begin
					if (tbl_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						lc_q    <= here_q + {{(ADDR_W - 7){1'b0}}, res.length_bytes};
						if (!lit_here_q && (dec.opcode == OP_LDB)) begin
							base_q <= dec.target;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-request bookkeeping of the sweep outcomes.
	always_ff @(posedge clk) begin
		if (dec_go) begin
			here_q      <= lc_q;
			lit_here_q  <= 1'b0;
			lab_found_q <= 1'b0;
			lab_idx_q   <= '0;
			ok_q        <= OK_NONE;
			oi_q        <= '0;
		end
		if (tbl_rsp.done) begin
			case (state_q)
				ST_LIT_HERE: begin
					lit_here_q <= tbl_rsp.hit;
					lit_idx_q  <= tbl_rsp.index;
					lit_dig_q  <= tbl_rsp.digits;
				end
				ST_SYM_HERE: begin
					lab_found_q <= tbl_rsp.hit;
					lab_idx_q   <= tbl_rsp.hit ? tbl_rsp.index : '0;
					if (dec.is_ret) begin
						ok_q <= OK_NONE;
						oi_q <= '0;
					end else if (dec.is_reg) begin
						ok_q <= OK_REGISTER;
						oi_q <= {2'b00, dec.nibble};
					end
				end
				ST_SYM_TGT: begin
					ok_q <= OK_SYMBOL;
					oi_q <= tbl_rsp.index;
				end
				ST_LIT_TGT: begin
					ok_q <= tbl_rsp.hit ? OK_LITERAL : OK_VALUE;
					oi_q <= tbl_rsp.hit ? tbl_rsp.index : '0;
				end
				default: begin
					oi_q <= oi_q;
				end
			endcase
		end
		if (out_load) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`ASSERT_RST(a_srch_idle, clk, arst_n, srch.start |-> !tbl_rsp.busy, "search issued while a sweep runs")
	`ASSERT_RST(a_tgt_ready, clk, arst_n, (srch.start && (state_q == ST_SYM_HERE)) |-> dec_rdy, "target used before decode finished")
	`ASSERT_NEXT(a_dec_enter, clk, arst_n, dec_go, state_q == ST_LIT_HERE, "decode request did not start the literal sweep")
	`ASSERT_RST(a_done_state, clk, arst_n, tbl_rsp.done |-> searching, "sweep finished outside a search state")
endmodule
`default_nettype wire

FILE: rtl/sid_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/sid_tables.sv
// Symbol and literal tables with their valid bits and the sequential search sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sid_tables (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sid_pkg::tbl_wr_t   wr,
	input  wire sid_pkg::srch_req_t req,
	output sid_pkg::srch_rsp_t      rsp
);
	import sid_pkg::*;

	logic [SYM_AW+SLOT_W-1:0] sym_ext;
	logic [LIT_AW+SLOT_W-1:0] lit_ext;
	logic                     sym_we;
	logic                     lit_we;
	logic [1:0]               we_vec;
	logic [SYMBOL_SLOTS-1:0]  sym_vld_q;
	logic [LITERAL_SLOTS-1:0] lit_vld_q;
	logic                     lit_live;
	logic [SYM_W-1:0]         sym_rdata;
	logic [LIT_W-1:0]         lit_rdata;

	logic                     run_q;
	logic                     sel_q;
	logic [ADDR_W-1:0]        key_q;
	logic [TBL_AW-1:0]        cnt_q;
	logic                     last;
	logic                     act_s1;
	logic                     last_s1;
	logic                     vld_s1;
	logic [TBL_AW-1:0]        idx_s1;
	logic                     match;
	logic                     done_q;
	logic                     hit_q;
	logic [TBL_AW-1:0]        hidx_q;
	logic [DIG_W-1:0]         hdig_q;
	logic [TBL_AW+SLOT_W-1:0] hidx_ext;

	// Slot indexes beyond the table size are dropped.
	assign sym_ext  = {{SYM_AW{1'b0}}, wr.index};
	assign lit_ext  = {{LIT_AW{1'b0}}, wr.index};
	assign sym_we   = wr.sym_we && (sym_ext < (SYM_AW + SLOT_W)'(SYMBOL_SLOTS));
	assign lit_we   = wr.lit_we && (lit_ext < (LIT_AW + SLOT_W)'(LITERAL_SLOTS));
	assign we_vec   = {sym_we, lit_we};
	// A literal with no digits never matches, so it is stored as unused.
	assign lit_live = wr.valid && (wr.digits != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_vld_q <= '0;
			lit_vld_q <= '0;
		end else begin
			if (sym_we) begin
				sym_vld_q[sym_ext[SYM_AW-1:0]] <= wr.valid;
			end
			if (lit_we) begin
				lit_vld_q[lit_ext[LIT_AW-1:0]] <= lit_live;
			end
		end
	end

	sid_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOL_SLOTS)) u_sym_ram (
		.clk   (clk),
		.we    (sym_we),
		.waddr (sym_ext[SYM_AW-1:0]),
		.wdata (wr.addr),
		.raddr (cnt_q[SYM_AW-1:0]),
		.rdata (sym_rdata)
	);

	sid_ram #(.WIDTH(LIT_W), .DEPTH(LITERAL_SLOTS)) u_lit_ram (
		.clk   (clk),
		.we    (lit_we),
		.waddr (lit_ext[LIT_AW-1:0]),
		.wdata ({wr.digits, wr.addr}),
		.raddr (cnt_q[LIT_AW-1:0]),
		.rdata (lit_rdata)
	);

	assign last = sel_q ? (cnt_q == TBL_AW'(LITERAL_SLOTS - 1))
	                    : (cnt_q == TBL_AW'(SYMBOL_SLOTS - 1));
	assign match = act_s1 && vld_s1 &&
	               (sel_q ? (lit_rdata[ADDR_W-1:0] == key_q) : (sym_rdata == key_q));

	// Sweep control: one read per cycle, compared on the registered read data; the last match wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
			act_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (req.start) begin
				run_q <= 1'b1;
				sel_q <= req.sel_lit;
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (run_q) begin
					cnt_q <= cnt_q + TBL_AW'(1);
					if (last) begin
						run_q <= 1'b0;
					end
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			act_s1  <= run_q;
			last_s1 <= run_q && last;
			done_q  <= act_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q <= req.key;
		end
		idx_s1 <= cnt_q;
		vld_s1 <= sel_q ? lit_vld_q[cnt_q[LIT_AW-1:0]] : sym_vld_q[cnt_q[SYM_AW-1:0]];
		if (match) begin
			hidx_q <= idx_s1;
			hdig_q <= lit_rdata[LIT_W-1:ADDR_W];
		end
	end

	assign hidx_ext   = {{SLOT_W{1'b0}}, hidx_q};
	assign rsp.busy   = run_q || act_s1;
	assign rsp.done   = done_q;
	assign rsp.hit    = hit_q;
	assign rsp.index  = hidx_ext[SLOT_W-1:0];
	assign rsp.digits = hdig_q;

	`ASSERT_RST(a_wr_quiet, clk, arst_n, (sym_we || lit_we) |-> !(run_q || act_s1), "table written during a sweep")
	`ASSERT_RST(a_wr_single, clk, arst_n, $onehot0(we_vec), "both tables written at once")
	`ASSERT_NEXT(a_sweep_runs, clk, arst_n, run_q && !last && !req.start, run_q, "sweep stopped early")
endmodule
`default_nettype wire

FILE: rtl/sid_decode.sv
// Instruction field decode and three-step target address calculation.
`timescale 1ns / 1ps
`default_nettype none
module sid_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [31:0]               instr_bytes,
	input  wire logic [sid_pkg::ADDR_W-1:0] here,
	input  wire logic [sid_pkg::ADDR_W-1:0] base,
	output sid_pkg::dec_t                  dec,
	output logic                           rdy
);
	import sid_pkg::*;

	logic              known_c;
	logic [7:0]        op_s1;
	logic              known_s1;
	logic              n_s1;
	logic              i_s1;
	logic              x_s1;
	logic              p_s1;
	logic              e_s1;
	logic [3:0]        nib_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] ta_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic [ADDR_W-1:0] ta_s2;
	logic [ADDR_W-1:0] tgt_q;
	logic              is_ret;
	logic              is_reg;
	logic              v_s1;
	logic              v_s2;
	logic              rdy_q;

	always_comb begin
		known_c = 1'b0;
		for (int k = 0; k < OP_COUNT; k++) begin
			if (OPCODE_SET[k] == {instr_bytes[31:26], 2'b00}) begin
				known_c = 1'b1;
			end
		end
	end

	assign is_ret = (op_s1 == OP_RSUB);
	assign is_reg = (op_s1 == OP_CLEAR);

	// Step one: fields, base-relative sum and pc; step two: sign fold of the
	// displacement; step three: pc-relative sum and target selection.
	always_ff @(posedge clk) begin
		if (start) begin
			op_s1    <= {instr_bytes[31:26], 2'b00};
			known_s1 <= known_c;
			n_s1     <= instr_bytes[25];
			i_s1     <= instr_bytes[24];
			x_s1     <= instr_bytes[23];
			p_s1     <= instr_bytes[21];
			e_s1     <= instr_bytes[20];
			nib_s1   <= instr_bytes[23:20];
			addr_s1  <= instr_bytes[19:0];
			ta_s1    <= {8'd0, instr_bytes[19:8]} + (instr_bytes[22] ? base : '0);
			pc_s1    <= here + PC_STEP;
		end
		ta_s2 <= (p_s1 && (ta_s1 > DISP_HALF)) ? (ta_s1 - DISP_SPAN) : ta_s1;
		if (is_ret || is_reg) begin
			tgt_q <= '0;
		end else if (e_s1) begin
			tgt_q <= addr_s1;
		end else if (p_s1) begin
			tgt_q <= ta_s2 + pc_s1;
		end else begin
			tgt_q <= ta_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rdy_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1 && !start;
			if (start) begin
				rdy_q <= 1'b0;
			end else if (v_s2) begin
				rdy_q <= 1'b1;
			end
		end
	end

	always_comb begin
		dec         = '0;
		dec.opcode  = op_s1;
		dec.known   = known_s1;
		dec.target  = tgt_q;
		dec.is_ret  = is_ret;
		dec.is_reg  = is_reg;
		dec.nibble  = nib_s1;
		if (is_ret) begin
			dec.format = FMT_3;
			dec.len    = 7'd3;
		end else if (is_reg) begin
			dec.format = FMT_2;
			dec.len    = 7'd2;
		end else begin
			dec.format  = e_s1 ? FMT_4 : FMT_3;
			dec.len     = e_s1 ? 7'd4 : 7'd3;
			dec.indexed = x_s1;
			if (n_s1 == i_s1) begin
				dec.mode = MODE_SIMPLE;
			end else if (n_s1) begin
				dec.mode = MODE_INDIRECT;
			end else begin
				dec.mode = MODE_IMMEDIATE;
			end
		end
	end

	assign rdy = rdy_q;
endmodule
`default_nettype wire
